### rtl/assert_macros.svh
// Assertion helpers for the checker file trl_checker.sv.
// Each macro expands to one labelled concurrent assertion on clk,
// held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property sampled on the rising edge of clk.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assert that a condition on one edge implies a condition on the next edge.
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

### rtl/trl_pkg.sv
// ----------------------------------------------------------------------------
// trl_pkg
// Widths, limits and pipeline control types shared by the trilateration
// pipeline modules.
// ----------------------------------------------------------------------------
package trl_pkg;

    // Coordinate and distance widths at the ports
    localparam int XW     = 32;
    localparam int DISTW  = 31;
    // Differences and sums of two coordinates
    localparam int AW     = 33;
    // Products of two differences
    localparam int PW     = 66;
    // Line constant and determinant
    localparam int CW     = 68;
    // Split point of the line constant for the numerator partial products
    localparam int SPLIT  = 34;
    // Partial product widths: high half and low half of the constant
    localparam int PHW    = CW - SPLIT + AW;
    localparam int PLW    = SPLIT + 1 + AW;
    // Cramer numerators
    localparam int NW     = 102;
    // Divider: remainder width, divisor width, quotient bits
    localparam int RW     = 102;
    localparam int DVW    = CW;
    localparam int QB     = 33;
    localparam int LANES  = 2;
    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;

    // Saturation bounds of a result coordinate
    localparam logic [XW-1:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [XW-1:0] NEG_MIN = 32'h8000_0000;

    // Control that travels with each item through the divider stages
    typedef struct packed {
        logic             valid;
        logic             found;
        logic [LANES-1:0] neg;
        logic [LANES-1:0] ovf;
    } div_ctl_t;

endpackage

### rtl/trl_front.sv
// ----------------------------------------------------------------------------
// trl_front
// Pivot choice, line coefficients and determinant: three register stages.
// ----------------------------------------------------------------------------
module trl_front
    import trl_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [XW-1:0]    first_x,
    input  logic signed [XW-1:0]    first_y,
    input  logic        [DISTW-1:0] first_dist,
    input  logic signed [XW-1:0]    second_x,
    input  logic signed [XW-1:0]    second_y,
    input  logic        [DISTW-1:0] second_dist,
    input  logic signed [XW-1:0]    third_x,
    input  logic signed [XW-1:0]    third_y,
    input  logic        [DISTW-1:0] third_dist,
    output logic                    out_valid,
    output logic signed [AW-1:0]    a1,
    output logic signed [AW-1:0]    b1,
    output logic signed [AW-1:0]    a2,
    output logic signed [AW-1:0]    b2,
    output logic signed [CW-1:0]    c1,
    output logic signed [CW-1:0]    c2,
    output logic signed [CW-1:0]    det
);

    logic signed [XW-1:0]    px, py, ux, uy, vx, vy;
    logic        [DISTW-1:0] pd, ud, vd;

    logic [2:0] valid_reg;

    // stage 1 registers
    logic signed [AW-1:0] a1_reg, b1_reg, a2_reg, b2_reg;
    logic signed [AW-1:0] sx1_reg, sy1_reg, sx2_reg, sy2_reg;
    logic        [XW-1:0] ds1_reg, ds2_reg;
    logic signed [XW-1:0] dd1_reg, dd2_reg;
    // stage 2 registers
    logic signed [AW-1:0] a1_s2_reg, b1_s2_reg, a2_s2_reg, b2_s2_reg;
    logic signed [PW-1:0] px1_reg, py1_reg, pd1_reg, px2_reg, py2_reg, pd2_reg;
    logic signed [PW-1:0] q1_reg, q2_reg;
    // stage 3 registers
    logic signed [AW-1:0] a1_s3_reg, b1_s3_reg, a2_s3_reg, b2_s3_reg;
    logic signed [CW-1:0] c1_reg, c2_reg, det_reg;

    // Pick a pivot whose x differs from both other anchors, where one exists
    always_comb
    begin
        priority if (first_x != second_x && first_x != third_x)
        begin
            px = first_x;  py = first_y;  pd = first_dist;
            ux = second_x; uy = second_y; ud = second_dist;
            vx = third_x;  vy = third_y;  vd = third_dist;
        end
        else if (first_x == second_x)
        begin
            px = third_x;  py = third_y;  pd = third_dist;
            ux = second_x; uy = second_y; ud = second_dist;
            vx = first_x;  vy = first_y;  vd = first_dist;
        end
        else
        begin
            px = second_x; py = second_y; pd = second_dist;
            ux = first_x;  uy = first_y;  ud = first_dist;
            vx = third_x;  vy = third_y;  vd = third_dist;
        end
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[1:0], in_valid};
    end

    // Stage 1: differences and sums
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg  <= AW'(px) - AW'(ux);
            b1_reg  <= AW'(py) - AW'(uy);
            a2_reg  <= AW'(px) - AW'(vx);
            b2_reg  <= AW'(py) - AW'(vy);
            sx1_reg <= AW'(px) + AW'(ux);
            sy1_reg <= AW'(py) + AW'(uy);
            sx2_reg <= AW'(px) + AW'(vx);
            sy2_reg <= AW'(py) + AW'(vy);
            ds1_reg <= XW'(pd) + XW'(ud);
            ds2_reg <= XW'(pd) + XW'(vd);
            dd1_reg <= $signed(XW'(pd)) - $signed(XW'(ud));
            dd2_reg <= $signed(XW'(pd)) - $signed(XW'(vd));
        end
    end

    // Stage 2: products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_s2_reg <= a1_reg;
            b1_s2_reg <= b1_reg;
            a2_s2_reg <= a2_reg;
            b2_s2_reg <= b2_reg;
            px1_reg   <= sx1_reg * a1_reg;
            py1_reg   <= sy1_reg * b1_reg;
            pd1_reg   <= $signed({1'b0, ds1_reg}) * dd1_reg;
            px2_reg   <= sx2_reg * a2_reg;
            py2_reg   <= sy2_reg * b2_reg;
            pd2_reg   <= $signed({1'b0, ds2_reg}) * dd2_reg;
            q1_reg    <= b2_reg * a1_reg;
            q2_reg    <= b1_reg * a2_reg;
        end
    end

    // Stage 3: line constants and determinant
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_s3_reg <= a1_s2_reg;
            b1_s3_reg <= b1_s2_reg;
            a2_s3_reg <= a2_s2_reg;
            b2_s3_reg <= b2_s2_reg;
            c1_reg    <= CW'(px1_reg) + CW'(py1_reg) - CW'(pd1_reg);
            c2_reg    <= CW'(px2_reg) + CW'(py2_reg) - CW'(pd2_reg);
            det_reg   <= CW'(q1_reg) - CW'(q2_reg);
        end
    end

    assign out_valid = valid_reg[2];
    assign a1        = a1_s3_reg;
    assign b1        = b1_s3_reg;
    assign a2        = a2_s3_reg;
    assign b2        = b2_s3_reg;
    assign c1        = c1_reg;
    assign c2        = c2_reg;
    assign det       = det_reg;

endmodule

### rtl/trl_numer.sv
// ----------------------------------------------------------------------------
// trl_numer
// Cramer numerators, magnitudes and divider operands: four register stages.
// ----------------------------------------------------------------------------
module trl_numer
    import trl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [AW-1:0] a1,
    input  logic signed [AW-1:0] b1,
    input  logic signed [AW-1:0] a2,
    input  logic signed [AW-1:0] b2,
    input  logic signed [CW-1:0] c1,
    input  logic signed [CW-1:0] c2,
    input  logic signed [CW-1:0] det,
    output div_ctl_t             out_ctl,
    output logic        [RW-1:0] num_x,
    output logic        [RW-1:0] num_y,
    output logic        [DVW-1:0] den
);

    logic signed [CW-1:0] opc [4];
    logic signed [AW-1:0] opb [4];

    logic [3:0] valid_reg;
    logic [2:0] found_reg;

    logic signed [PHW-1:0] ph_reg [4];
    logic signed [PLW-1:0] pl_reg [4];
    logic signed [CW-1:0]  det4_reg, det5_reg;
    logic signed [NW-1:0]  full [4];
    logic signed [NW-1:0]  nx_reg, ny_reg;
    logic signed [NW-1:0]  nx_neg, ny_neg;
    logic signed [CW-1:0]  det_neg;
    logic        [NW-2:0]  anx_reg, any_reg;
    logic        [CW-2:0]  ad_reg;
    logic        [LANES-1:0] neg6_reg, neg7_reg;
    logic        [RW-1:0]  num_x_reg, num_y_reg;
    logic        [DVW-1:0] den_reg;

    // Operand pairs: x numerator c1*b2 - c2*b1, y numerator c2*a1 - c1*a2
    always_comb
    begin
        opc[0] = c1; opb[0] = b2;
        opc[1] = c2; opb[1] = b1;
        opc[2] = c2; opb[2] = a1;
        opc[3] = c1; opb[3] = a2;
    end

    // Advance valid and found flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            found_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
            found_reg <= {found_reg[1:0], (det4_reg != '0)};
        end
    end

    // Stage 4: partial products, constant split in a signed high and unsigned low half
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                ph_reg[k] <= $signed(opc[k][CW-1:SPLIT]) * opb[k];
                pl_reg[k] <= $signed({1'b0, opc[k][SPLIT-1:0]}) * opb[k];
            end
            det4_reg <= det;
        end
    end

    // Recombine the partial products
    always_comb
    begin
        for (int k = 0; k < 4; k++)
            full[k] = (NW'(ph_reg[k]) <<< SPLIT) + NW'(pl_reg[k]);
    end

    // Stage 5: numerators
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg   <= full[0] - full[1];
            ny_reg   <= full[2] - full[3];
            det5_reg <= det4_reg;
        end
    end

    assign nx_neg  = -nx_reg;
    assign ny_neg  = -ny_reg;
    assign det_neg = -det5_reg;

    // Stage 6: magnitudes and result signs
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            anx_reg          <= nx_reg[NW-1] ? nx_neg[NW-2:0] : nx_reg[NW-2:0];
            any_reg          <= ny_reg[NW-1] ? ny_neg[NW-2:0] : ny_reg[NW-2:0];
            ad_reg           <= det5_reg[CW-1] ? det_neg[CW-2:0] : det5_reg[CW-2:0];
            neg6_reg[LANE_X] <= nx_reg[NW-1] ^ det5_reg[CW-1];
            neg6_reg[LANE_Y] <= ny_reg[NW-1] ^ det5_reg[CW-1];
        end
    end

    // Stage 7: rounded dividend |n| + |det| over divisor 2|det|
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_x_reg <= RW'(anx_reg) + RW'(ad_reg);
            num_y_reg <= RW'(any_reg) + RW'(ad_reg);
            den_reg   <= {ad_reg, 1'b0};
            neg7_reg  <= neg6_reg;
        end
    end

    always_comb
    begin
        out_ctl       = '0;
        out_ctl.valid = valid_reg[3];
        out_ctl.found = found_reg[2];
        out_ctl.neg   = neg7_reg;
    end

    assign num_x = num_x_reg;
    assign num_y = num_y_reg;
    assign den   = den_reg;

endmodule

### rtl/trl_div.sv
// ----------------------------------------------------------------------------
// trl_div
// Two-lane pipelined restoring divider, one quotient bit per stage, with an
// overflow check up front and a final sign and saturation stage.
// ----------------------------------------------------------------------------
module trl_div
    import trl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  div_ctl_t             in_ctl,
    input  logic [RW-1:0]        num_x,
    input  logic [RW-1:0]        num_y,
    input  logic [DVW-1:0]       den,
    output logic                 out_valid,
    output logic signed [XW-1:0] pos_x,
    output logic signed [XW-1:0] pos_y,
    output logic                 found
);

    div_ctl_t       ctl_reg [QB];
    logic [RW-1:0]  rem_reg [QB][LANES];
    logic [QB-1:0]  quo_reg [QB][LANES];
    logic [DVW-1:0] den_reg [QB];

    logic           out_valid_reg;
    logic           found_reg;
    logic [XW-1:0]  res_reg [LANES];
    logic [XW-1:0]  res_next [LANES];

    for (genvar k = 0; k < QB; k++)
    begin : g_stage
        div_ctl_t       src_ctl, ctl_next;
        logic [RW-1:0]  src_rem [LANES];
        logic [QB-1:0]  src_quo [LANES];
        logic [DVW-1:0] src_den;
        logic [RW-1:0]  rem_next [LANES];
        logic [QB-1:0]  quo_next [LANES];
        logic [RW-1:0]  shifted;

        // Select this stage's source: the ports for the first, else the stage before
        if (k == 0)
        begin : g_first
            always_comb
            begin
                src_ctl            = in_ctl;
                src_rem[LANE_X]    = num_x;
                src_rem[LANE_Y]    = num_y;
                src_quo[LANE_X]    = '0;
                src_quo[LANE_Y]    = '0;
                src_den            = den;
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                src_ctl = ctl_reg[k-1];
                src_rem = rem_reg[k-1];
                src_quo = quo_reg[k-1];
                src_den = den_reg[k-1];
            end
        end

        assign shifted = RW'(src_den) << (QB - 1 - k);

        // Try one subtraction per lane; flag a quotient beyond QB bits up front
        always_comb
        begin
            ctl_next = src_ctl;
            for (int l = 0; l < LANES; l++)
            begin
                if (k == 0)
                    ctl_next.ovf[l] = (src_rem[l] >= (RW'(src_den) << QB));
                rem_next[l] = src_rem[l];
                quo_next[l] = src_quo[l];
                if (src_rem[l] >= shifted)
                begin
                    rem_next[l]           = src_rem[l] - shifted;
                    quo_next[l][QB-1-k]   = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_reg[k] <= '0;
            else if (en)
                ctl_reg[k] <= ctl_next;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                quo_reg[k] <= quo_next;
                den_reg[k] <= src_den;
            end
        end
    end

    // Apply the sign and saturate; zero when the geometry is degenerate
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            priority if (!ctl_reg[QB-1].found)
                res_next[l] = '0;
            else if (!ctl_reg[QB-1].neg[l])
            begin
                if (ctl_reg[QB-1].ovf[l] || quo_reg[QB-1][l] > QB'(POS_MAX))
                    res_next[l] = POS_MAX;
                else
                    res_next[l] = quo_reg[QB-1][l][XW-1:0];
            end
            else
            begin
                if (ctl_reg[QB-1].ovf[l] || quo_reg[QB-1][l] > QB'(NEG_MIN))
                    res_next[l] = NEG_MIN;
                else
                    res_next[l] = -quo_reg[QB-1][l][XW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= ctl_reg[QB-1].valid;
            found_reg     <= ctl_reg[QB-1].found;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign pos_x     = $signed(res_reg[LANE_X]);
    assign pos_y     = $signed(res_reg[LANE_Y]);

endmodule

### rtl/three_circle_trilateration.sv
// Pipeline: 3 line stages, 4 numerator stages, 33 divider bit stages and 1
// saturation stage between input transfer and result.
// Throughput: one position fix per cycle; the pipeline holds as a whole while
// a result waits under out_stall, and in_stall is then raised.
// Reset: rst_n clears every valid bit asynchronously; data registers keep
// their contents.
// ----------------------------------------------------------------------------
// three_circle_trilateration
// Locates the meeting point of three circles in Q16.16 fixed point.
// ----------------------------------------------------------------------------
module three_circle_trilateration
    import trl_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [XW-1:0]    first_x,
    input  logic signed [XW-1:0]    first_y,
    input  logic        [DISTW-1:0] first_dist,
    input  logic signed [XW-1:0]    second_x,
    input  logic signed [XW-1:0]    second_y,
    input  logic        [DISTW-1:0] second_dist,
    input  logic signed [XW-1:0]    third_x,
    input  logic signed [XW-1:0]    third_y,
    input  logic        [DISTW-1:0] third_dist,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [XW-1:0]    pos_x,
    output logic signed [XW-1:0]    pos_y,
    output logic                    found
);

    logic                 en;
    logic                 front_valid;
    logic signed [AW-1:0] a1, b1, a2, b2;
    logic signed [CW-1:0] c1, c2, det;
    div_ctl_t             numer_ctl;
    logic [RW-1:0]        num_x, num_y;
    logic [DVW-1:0]       den;

    // Advance the whole pipeline unless a finished result is held
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    trl_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (in_valid),
        .first_x     (first_x),
        .first_y     (first_y),
        .first_dist  (first_dist),
        .second_x    (second_x),
        .second_y    (second_y),
        .second_dist (second_dist),
        .third_x     (third_x),
        .third_y     (third_y),
        .third_dist  (third_dist),
        .out_valid   (front_valid),
        .a1          (a1),
        .b1          (b1),
        .a2          (a2),
        .b2          (b2),
        .c1          (c1),
        .c2          (c2),
        .det         (det)
    );

    trl_numer u_numer (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (front_valid),
        .a1       (a1),
        .b1       (b1),
        .a2       (a2),
        .b2       (b2),
        .c1       (c1),
        .c2       (c2),
        .det      (det),
        .out_ctl  (numer_ctl),
        .num_x    (num_x),
        .num_y    (num_y),
        .den      (den)
    );

    trl_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_ctl    (numer_ctl),
        .num_x     (num_x),
        .num_y     (num_y),
        .den       (den),
        .out_valid (out_valid),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .found     (found)
    );

endmodule

### rtl/trl_checker.sv
// ----------------------------------------------------------------------------
// trl_checker
// Port-level checks of the trilateration block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module trl_checker
    import trl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic signed [XW-1:0] pos_x,
    input  logic signed [XW-1:0] pos_y,
    input  logic                 found
);

    // A held result keeps its contents until transfer
    `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(pos_x) && $stable(pos_y) && $stable(found), "held result changed")

    // A degenerate fix reports a zero position
    `ASSERT_CLK(a_zero_when_lost, (out_valid && !found) |-> (pos_x == '0 && pos_y == '0), "degenerate fix with nonzero position")

    // The input holds off only while a result waits downstream
    `ASSERT_CLK(a_stall_cause, in_stall |-> (out_valid && out_stall), "input stalled without a held result")

    // With the output free the input takes an item in the same cycle
    `ASSERT_CLK(a_no_idle_stall, (in_valid && !out_stall) |-> !in_stall, "input stalled while output free")

endmodule

bind three_circle_trilateration trl_checker u_trl_checker (.*);

### verif/trl_fix_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trl_fix_checker
// Watches both channels of the trilateration block, predicts each position
// fix from the accepted anchors and compares it with the result that leaves.
// ----------------------------------------------------------------------------
module trl_fix_checker
    import trl_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic signed [XW-1:0]    first_x,
    input  logic signed [XW-1:0]    first_y,
    input  logic        [DISTW-1:0] first_dist,
    input  logic signed [XW-1:0]    second_x,
    input  logic signed [XW-1:0]    second_y,
    input  logic        [DISTW-1:0] second_dist,
    input  logic signed [XW-1:0]    third_x,
    input  logic signed [XW-1:0]    third_y,
    input  logic        [DISTW-1:0] third_dist,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic signed [XW-1:0]    pos_x,
    input  logic signed [XW-1:0]    pos_y,
    input  logic                    found,
    output int                      fail_count,
    output int                      pending
);

    typedef logic signed [159:0] big_t;

    typedef struct {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic                 ok;
    } fix_t;

    fix_t fix_q[$];

    function automatic big_t coord_big(input logic signed [XW-1:0] v);
        return {{(160-XW){v[XW-1]}}, v};
    endfunction

    function automatic big_t dist_big(input logic [DISTW-1:0] v);
        return {{(160-DISTW){1'b0}}, v};
    endfunction

    // Round num / (2*det) to nearest, ties away from zero, then saturate
    function automatic logic [XW-1:0] round_quot(input big_t num, input big_t det);
        logic        neg;
        logic [159:0] an, ad, q;
        neg = (num < 0) != (det < 0);
        an  = (num < 0) ? -num : num;
        ad  = (det < 0) ? -det : det;
        q   = (an + ad) / (ad + ad);
        if (!neg)
            return (q > 160'h7FFF_FFFF) ? POS_MAX : q[XW-1:0];
        if (q > 160'h8000_0000)
            return NEG_MIN;
        return -q[XW-1:0];
    endfunction

    // Predict one fix: pick the pivot, build two lines, solve by Cramer's rule
    function automatic fix_t predict_fix(
        input big_t x1, input big_t y1, input big_t d1,
        input big_t x2, input big_t y2, input big_t d2,
        input big_t x3, input big_t y3, input big_t d3);
        fix_t f;
        big_t px, py, pd, ux, uy, ud, vx, vy, vd;
        big_t a1, b1, c1, a2, b2, c2, det, nx, ny;
        f.x = '0;
        f.y = '0;
        f.ok = 1'b0;
        if (x1 == x2 && x1 == x3)
            return f;
        if (x1 != x2 && x1 != x3) begin
            px = x1; py = y1; pd = d1; ux = x2; uy = y2; ud = d2;
            vx = x3; vy = y3; vd = d3;
        end
        else if (x1 == x2) begin
            px = x3; py = y3; pd = d3; ux = x2; uy = y2; ud = d2;
            vx = x1; vy = y1; vd = d1;
        end
        else begin
            px = x2; py = y2; pd = d2; ux = x1; uy = y1; ud = d1;
            vx = x3; vy = y3; vd = d3;
        end
        a1 = px - ux;
        b1 = py - uy;
        c1 = (px + ux) * a1 + (py + uy) * b1 - (pd + ud) * (pd - ud);
        a2 = px - vx;
        b2 = py - vy;
        c2 = (px + vx) * a2 + (py + vy) * b2 - (pd + vd) * (pd - vd);
        det = b2 * a1 - b1 * a2;
        if (det == 0)
            return f;
        nx = c1 * b2 - c2 * b1;
        ny = c2 * a1 - c1 * a2;
        f.x = round_quot(nx, det);
        f.y = round_quot(ny, det);
        f.ok = 1'b1;
        return f;
    endfunction

    // Predict on every input transfer, compare on every output transfer
    always @(posedge clk or negedge rst_n)
    begin
        fix_t want;
        if (!rst_n) begin
            fail_count <= 0;
            fix_q.delete();
        end
        else begin
            if (in_valid && !in_stall)
                fix_q.push_back(predict_fix(
                    coord_big(first_x), coord_big(first_y), dist_big(first_dist),
                    coord_big(second_x), coord_big(second_y), dist_big(second_dist),
                    coord_big(third_x), coord_big(third_y), dist_big(third_dist)));
            if (out_valid && !out_stall) begin
                if (fix_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: result with nothing expected x=%h y=%h found=%b",
                                 $realtime, pos_x, pos_y, found);
                    fail_count <= fail_count + 1;
                end
                else begin
                    want = fix_q.pop_front();
                    if (want.x !== pos_x || want.y !== pos_y || want.ok !== found) begin
                        if (fail_count < 10)
                            $display("%0t: mismatch exp x=%h y=%h found=%b got x=%h y=%h found=%b",
                                     $realtime, want.x, want.y, want.ok, pos_x, pos_y, found);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
        // Track the number of fixes still in flight
        pending = fix_q.size();
    end

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives anchor sets into the trilateration block under random idling and
// output stalls; a checker beside the block predicts and compares each fix.
// ----------------------------------------------------------------------------
module tb_top;
    import trl_pkg::*;

    localparam int RANDOM_FIXES = 1130;
    localparam int CYCLE_LIMIT  = 300000;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic signed [XW-1:0]    first_x, first_y, second_x, second_y, third_x, third_y;
    logic        [DISTW-1:0] first_dist, second_dist, third_dist;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [XW-1:0]    pos_x, pos_y;
    logic                    found;
    int                      fail_count;
    int                      pending;
    int                      cycles;
    logic                    quiet;

    three_circle_trilateration u_top (.*);

    trl_fix_checker u_chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Stop a hung run
    initial
    begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    // Stall the result channel at random, except in the quiet stretch
    always @(negedge clk)
    begin
        out_stall <= !quiet && ($urandom_range(99) < 16);
    end

    function automatic logic signed [XW-1:0] rand_coord(input int sh);
        longint span;
        span = longint'(1) << sh;
        return XW'(longint'($urandom) % (2 * span + 1) - span);
    endfunction

    function automatic logic [DISTW-1:0] range_to(input logic signed [XW-1:0] ax,
        input logic signed [XW-1:0] ay, input logic signed [XW-1:0] tx,
        input logic signed [XW-1:0] ty);
        real dx, dy, d;
        dx = real'(ax) - real'(tx);
        dy = real'(ay) - real'(ty);
        d  = $sqrt(dx * dx + dy * dy) + real'($urandom_range(0, 6)) - 3.0;
        if (d < 0.0)
            d = 0.0;
        if (d > 2147483647.0)
            d = 2147483647.0;
        return DISTW'(longint'(d));
    endfunction

    // Present one anchor set and hold it until the transfer
    task automatic send_fix(input logic signed [XW-1:0] x1, y1, input logic [DISTW-1:0] r1,
                            input logic signed [XW-1:0] x2, y2, input logic [DISTW-1:0] r2,
                            input logic signed [XW-1:0] x3, y3, input logic [DISTW-1:0] r3);
        if (!quiet && $urandom_range(99) < 16) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        first_x = x1; first_y = y1; first_dist = r1;
        second_x = x2; second_y = y2; second_dist = r2;
        third_x = x3; third_y = y3; third_dist = r3;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Anchors around a true point, with ranges that agree with it
    task automatic send_located(input int sh);
        logic signed [XW-1:0] tx, ty, x1, y1, x2, y2, x3, y3;
        tx = rand_coord(sh);
        ty = rand_coord(sh);
        x1 = rand_coord(sh); y1 = rand_coord(sh);
        x2 = rand_coord(sh); y2 = rand_coord(sh);
        x3 = rand_coord(sh); y3 = rand_coord(sh);
        // share an x now and then so that every pivot choice is taken
        case ($urandom_range(9))
            0: x2 = x1;
            1: x3 = x1;
            2: x3 = x2;
            3: begin x2 = x1; x3 = x1; end
            default: ;
        endcase
        send_fix(x1, y1, range_to(x1, y1, tx, ty), x2, y2, range_to(x2, y2, tx, ty),
                 x3, y3, range_to(x3, y3, tx, ty));
    endtask

    initial
    begin
        int sel;
        logic signed [XW-1:0] mx, mn;
        logic [DISTW-1:0] dmax;
        mx = POS_MAX;
        mn = NEG_MIN;
        dmax = '1;
        quiet = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        first_x = '0; first_y = '0; first_dist = '0;
        second_x = '0; second_y = '0; second_dist = '0;
        third_x = '0; third_y = '0; third_dist = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: all x equal, each pivot choice, parallel lines, extremes
        send_fix(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_fix(32'sh10000, 0, 1, 32'sh10000, 32'sh50000, 2, 32'sh10000, -5, 3);
        send_fix(0, 0, 32'sh50000, 32'sh30000, 0, 32'sh40000, 0, 32'sh80000, 32'sh50000);
        send_fix(0, 0, 32'sh50000, 0, 32'sh80000, 32'sh50000, 32'sh30000, 0, 32'sh40000);
        send_fix(32'sh30000, 0, 32'sh40000, 0, 0, 32'sh50000, 0, 32'sh80000, 32'sh50000);
        send_fix(0, 0, 32'sh50000, 32'sh30000, 0, 32'sh40000, 32'sh60000, 0, 32'sh10000);
        send_fix(0, 0, 7, 32'sh10000, 32'sh10000, 9, 32'sh20000, 32'sh20000, 11);
        send_fix(mx, mx, dmax, mn, mn, dmax, mx, mn, dmax);
        send_fix(mn, mx, 0, mx, mn, 0, mn, mn, dmax);
        send_fix(mx, 0, 0, mn, 0, 0, 0, mx, 0);
        send_fix(0, 0, dmax, 1, 0, 0, 0, 1, 0);
        send_fix(0, 0, 0, 1, 0, dmax, 0, 1, 0);
        send_fix(0, 0, 0, 2, 0, 1, 0, 2, 1);
        send_fix(-1, -1, 1, 1, -1, 1, 0, 1, 1);
        send_fix(mn, mn, dmax, mn + 1, mn, 0, mn, mn + 1, 0);
        send_fix(mx, mx, 0, mx - 1, mx, dmax, mx, mx - 1, 0);
        send_fix(32'sh5555_5555, 32'shAAAA_AAAA, 31'h5555_5555,
                 32'shAAAA_AAAA, 32'sh5555_5555, 31'h2AAA_AAAA,
                 32'sh0F0F_0F0F, 32'shF0F0_F0F0, 31'h7F00_00FF);

        // Random: mostly consistent geometry, some raw noise and degenerate sets
        for (int n = 0; n < RANDOM_FIXES; n++) begin
            quiet = (n >= 300 && n < 500);
            // hold off until the pipeline has drained
            if (n == 600) begin
                in_valid = 1'b0;
                while (pending != 0)
                    @(negedge clk);
            end
            sel = $urandom_range(99);
            if (sel < 70)
                send_located((sel < 50) ? $urandom_range(8, 22) : $urandom_range(23, 30));
            else if (sel < 85)
                send_fix($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom);
            else begin
                // anchors on one straight line
                mx = rand_coord(20);
                mn = rand_coord(10);
                send_fix(mx, mn, $urandom_range(0, 1 << 24), mx + mn, mn + mn,
                         $urandom_range(0, 1 << 24), mx + 3 * mn, 4 * mn,
                         $urandom_range(0, 1 << 24));
            end
        end
        in_valid = 1'b0;
        quiet = 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
        if (fail_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
